>>> sv/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define CHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define CHK_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/btok_pkg.sv
package btok_pkg;

  localparam int MAX_DEPTH_DEF = 32;

  localparam int IQ_DEPTH = 4;
  localparam int IQ_AW    = $clog2(IQ_DEPTH);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;

  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    TK_ODICT  = 3'd0,
    TK_OLIST  = 3'd1,
    TK_CLIST  = 3'd2,
    TK_CDICT  = 3'd3,
    TK_INT    = 3'd4,
    TK_SHDR   = 3'd5,
    TK_SBYTE  = 3'd6,
    TK_FINISH = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INT_OPEN  = 3'd1,
    ST_UNMATCHED = 3'd2,
    ST_BAD       = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  typedef struct packed {
    logic is_digit;
    logic is_d;
    logic is_l;
    logic is_i;
    logic is_e;
    logic is_colon;
    logic is_ws;
    logic is_plus;
    logic is_minus;
  } class_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last_byte;
    class_t     cls;
  } iq_entry_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] ival;
    logic [30:0] slen;
    logic [7:0]  data;
    logic [5:0]  depth;
    status_t     status;
    logic        last;
  } res_t;

endpackage

>>> sv/btok_front.sv
module btok_front import btok_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [7:0] data_byte,
  input  logic      stream_end,
  output logic      iq_valid,
  output iq_entry_t iq_entry,
  input  logic      iq_pop
);

  iq_entry_t          ents [IQ_DEPTH];
  logic [IQ_AW-1:0]   wr_ptr;
  logic [IQ_AW-1:0]   rd_ptr;
  logic [IQ_AW:0]     count;
  iq_entry_t          new_ent;
  logic               push;

  always_comb begin
    new_ent.data           = data_byte;
    new_ent.last_byte      = stream_end;
    new_ent.cls.is_digit   = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    new_ent.cls.is_d       = (data_byte == CH_D);
    new_ent.cls.is_l       = (data_byte == CH_L);
    new_ent.cls.is_i       = (data_byte == CH_I);
    new_ent.cls.is_e       = (data_byte == CH_E);
    new_ent.cls.is_colon   = (data_byte == CH_COLON);
    new_ent.cls.is_ws      = (data_byte == CH_SPACE) ||
                             ((data_byte >= CH_TAB) && (data_byte <= CH_CR));
    new_ent.cls.is_plus    = (data_byte == CH_PLUS);
    new_ent.cls.is_minus   = (data_byte == CH_MINUS);
  end

  assign in_ready = (count != (IQ_AW + 1)'(IQ_DEPTH));
  assign push     = in_valid && in_ready;
  assign iq_valid = (count != '0);
  assign iq_entry = ents[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ents[wr_ptr] <= new_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + IQ_AW'(1);
      if (iq_pop) rd_ptr <= rd_ptr + IQ_AW'(1);
      case ({push, iq_pop})
        2'b10:   count <= count + (IQ_AW + 1)'(1);
        2'b01:   count <= count - (IQ_AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/btok_parse.sv
module btok_parse import btok_pkg::*; #(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      iq_valid,
  input  iq_entry_t iq_entry,
  output logic      iq_pop,
  input  logic      oq_room,
  output res_t      res0,
  output res_t      res1,
  output logic [1:0] res_n
);

  localparam int CNT_W = $clog2(MAX_DEPTH + 1);

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_INT  = 5'b00010,
    M_LEN  = 5'b00100,
    M_STR  = 5'b01000,
    M_DONE = 5'b10000
  } mode_t;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_DIGITS = 2'd1,
    PH_STOP   = 2'd2
  } phase_t;

  mode_t              mode, mode_next;
  phase_t             phase, phase_next;
  logic [63:0]        int_accum, int_accum_next;
  logic               int_negative, int_negative_next;
  logic [30:0]        length_accum, length_accum_next;
  logic [30:0]        bytes_left, bytes_left_next;
  logic [CNT_W-1:0]   stack_count, stack_count_next;
  // bit 0 is the innermost container: 1 list, 0 dict
  logic [MAX_DEPTH-1:0] stack, stack_next;

  res_t        r0, r1;
  logic [1:0]  n;
  logic [34:0] len_wide;
  logic [3:0]  digit;
  phase_t      ph;
  status_t     end_st;

  function automatic res_t mk_res(kind_t k, logic [CNT_W-1:0] d, status_t s);
    res_t r;
    r        = '0;
    r.kind   = k;
    r.depth  = 6'(d);
    r.status = s;
    return r;
  endfunction

  assign iq_pop = iq_valid && oq_room;
  assign digit  = iq_entry.data[3:0];
  assign len_wide = (35'(length_accum) << 3) + (35'(length_accum) << 1) + 35'(digit);

  always_comb begin
    mode_next         = mode;
    phase_next        = phase;
    int_accum_next    = int_accum;
    int_negative_next = int_negative;
    length_accum_next = length_accum;
    bytes_left_next   = bytes_left;
    stack_count_next  = stack_count;
    stack_next        = stack;
    r0                = '0;
    r1                = '0;
    n                 = 2'd0;
    ph                = phase;
    end_st            = ST_OK;

    unique case (mode)
      M_STR: begin
        r0      = mk_res(TK_SBYTE, stack_count, ST_OK);
        r0.data = iq_entry.data;
        n       = 2'd1;
        bytes_left_next = bytes_left - 31'd1;
        if (bytes_left == 31'd1) mode_next = M_IDLE;
      end
      M_LEN: begin
        if (iq_entry.cls.is_digit) begin
          length_accum_next = (len_wide > 35'(LEN_MAX)) ? LEN_MAX : len_wide[30:0];
        end else if (iq_entry.cls.is_colon) begin
          r0      = mk_res(TK_SHDR, stack_count, ST_OK);
          r0.slen = length_accum;
          n       = 2'd1;
          bytes_left_next   = length_accum;
          length_accum_next = '0;
          mode_next = (length_accum == '0) ? M_IDLE : M_STR;
        end else begin
          r0 = mk_res(TK_FINISH, stack_count, ST_BAD);
          n  = 2'd1;
          mode_next = M_DONE;
        end
      end
      M_INT: begin
        if (iq_entry.cls.is_e) begin
          r0      = mk_res(TK_INT, stack_count, ST_OK);
          r0.ival = int_negative ? (64'd0 - int_accum) : int_accum;
          n       = 2'd1;
          int_accum_next    = '0;
          phase_next        = PH_START;
          int_negative_next = 1'b0;
          mode_next         = M_IDLE;
        end else if (phase == PH_START && iq_entry.cls.is_ws) begin
          // skip leading white space
        end else if (phase == PH_START &&
                     (iq_entry.cls.is_plus || iq_entry.cls.is_minus)) begin
          int_negative_next = iq_entry.cls.is_minus;
          phase_next        = PH_DIGITS;
        end else begin
          if (phase == PH_START || phase == PH_DIGITS) begin
            ph = iq_entry.cls.is_digit ? PH_DIGITS : PH_STOP;
          end
          phase_next = ph;
          if (ph == PH_DIGITS) begin
            int_accum_next = (int_accum << 3) + (int_accum << 1) + 64'(digit);
          end
        end
      end
      M_IDLE: begin
        if (iq_entry.cls.is_d || iq_entry.cls.is_l) begin
          if (stack_count == CNT_W'(MAX_DEPTH)) begin
            r0 = mk_res(TK_FINISH, stack_count, ST_OVERFLOW);
            mode_next = M_DONE;
          end else begin
            stack_next       = (stack << 1) | MAX_DEPTH'(iq_entry.cls.is_l);
            stack_count_next = stack_count + CNT_W'(1);
            r0 = mk_res(iq_entry.cls.is_l ? TK_OLIST : TK_ODICT, stack_count_next,
                        ST_OK);
          end
          n = 2'd1;
        end else if (iq_entry.cls.is_i) begin
          int_accum_next    = '0;
          phase_next        = PH_START;
          int_negative_next = 1'b0;
          mode_next         = M_INT;
        end else if (iq_entry.cls.is_e) begin
          if (stack_count == '0) begin
            r0 = mk_res(TK_FINISH, stack_count, ST_UNMATCHED);
            n  = 2'd1;
            mode_next = M_DONE;
          end else begin
            stack_count_next = stack_count - CNT_W'(1);
            stack_next       = stack >> 1;
            if (stack[0]) begin
              r0 = mk_res(TK_CLIST, stack_count_next, ST_OK);
              n  = 2'd1;
            end else begin
              r0 = mk_res(TK_CDICT, stack_count_next, ST_OK);
              n  = 2'd1;
              // closing the root dict ends the parse
              if (stack_count_next == '0) begin
                r1 = mk_res(TK_FINISH, stack_count_next, ST_OK);
                n  = 2'd2;
                mode_next = M_DONE;
              end
            end
          end
        end else if (iq_entry.cls.is_digit) begin
          length_accum_next = 31'(digit);
          mode_next         = M_LEN;
        end else begin
          r0 = mk_res(TK_FINISH, stack_count, (stack_count == '0) ? ST_OK : ST_BAD);
          n  = 2'd1;
          mode_next = M_DONE;
        end
      end
      M_DONE: begin
      end
      default: begin
      end
    endcase

    if (iq_entry.last_byte) begin
      if (mode_next != M_DONE) begin
        if (mode_next == M_INT) begin
          end_st = ST_INT_OPEN;
        end else if (mode_next == M_LEN || mode_next == M_STR) begin
          end_st = ST_BAD;
        end else begin
          end_st = (stack_count_next == '0) ? ST_OK : ST_BAD;
        end
        if (n == 2'd0) begin
          r0 = mk_res(TK_FINISH, stack_count_next, end_st);
          n  = 2'd1;
        end else begin
          r1 = mk_res(TK_FINISH, stack_count_next, end_st);
          n  = 2'd2;
        end
      end
      // return to the start state for the next stream
      mode_next         = M_IDLE;
      phase_next        = PH_START;
      int_accum_next    = '0;
      int_negative_next = 1'b0;
      length_accum_next = '0;
      bytes_left_next   = '0;
      stack_count_next  = '0;
    end

    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;
  end

  assign res0  = r0;
  assign res1  = r1;
  assign res_n = iq_pop ? n : 2'd0;

  always_ff @(posedge clk) begin
    if (iq_pop) stack <= stack_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      phase        <= PH_START;
      int_accum    <= '0;
      int_negative <= 1'b0;
      length_accum <= '0;
      bytes_left   <= '0;
      stack_count  <= '0;
    end else if (iq_pop) begin
      mode         <= mode_next;
      phase        <= phase_next;
      int_accum    <= int_accum_next;
      int_negative <= int_negative_next;
      length_accum <= length_accum_next;
      bytes_left   <= bytes_left_next;
      stack_count  <= stack_count_next;
    end
  end

endmodule

>>> sv/btok_outq.sv
module btok_outq import btok_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  res_t        res0,
  input  res_t        res1,
  input  logic [1:0]  res_n,
  output logic        oq_room,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_res
);

  res_t              q [OQ_DEPTH];
  logic [OQ_AW-1:0]  wr_ptr;
  logic [OQ_AW-1:0]  wr_ptr1;
  logic [OQ_AW-1:0]  rd_ptr;
  logic [OQ_AW:0]    count;
  logic              pop;

  assign wr_ptr1   = wr_ptr + OQ_AW'(1);
  assign out_valid = (count != '0);
  assign out_res   = q[rd_ptr];
  assign pop       = out_valid && out_ready;
  // room for the largest burst of one input byte
  assign oq_room   = (count <= (OQ_AW + 1)'(OQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (res_n != 2'd0) q[wr_ptr] <= res0;
    if (res_n == 2'd2) q[wr_ptr1] <= res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_AW'(res_n);
      if (pop) rd_ptr <= rd_ptr + OQ_AW'(1);
      count <= count + (OQ_AW + 1)'(res_n) - (OQ_AW + 1)'(pop);
    end
  end

endmodule

>>> sv/bencode_stream_tokenizer_core.sv
// Path: a byte accepted into the input queue is parsed from the queue head, and its
// tokens are written into the result queue; the parser holds while that queue lacks room.
// Throughput: one byte per cycle while the result queue has room; a byte that makes two
// tokens (root dict close, or token plus stream-end finish) writes both; they leave singly.
// Reset: synchronous, active high; empties both queues and returns the parser to idle
// with an empty container stack. Stack entries themselves are not cleared.
module bencode_stream_tokenizer_core import btok_pkg::*; #(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               stream_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         token_kind,
  output logic signed [63:0] int_value,
  output logic [30:0]        string_length,
  output logic [7:0]         out_byte,
  output logic [5:0]         nest_depth,
  output logic [2:0]         status,
  output logic               last_result
);

  logic       iq_valid;
  iq_entry_t  iq_entry;
  logic       iq_pop;
  logic       oq_room;
  res_t       res0, res1, out_res;
  logic [1:0] res_n;

  btok_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .stream_end (stream_end),
    .iq_valid   (iq_valid),
    .iq_entry   (iq_entry),
    .iq_pop     (iq_pop)
  );

  btok_parse #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .iq_valid (iq_valid),
    .iq_entry (iq_entry),
    .iq_pop   (iq_pop),
    .oq_room  (oq_room),
    .res0     (res0),
    .res1     (res1),
    .res_n    (res_n)
  );

  btok_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .res0      (res0),
    .res1      (res1),
    .res_n     (res_n),
    .oq_room   (oq_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign token_kind    = out_res.kind;
  assign int_value     = $signed(out_res.ival);
  assign string_length = out_res.slen;
  assign out_byte      = out_res.data;
  assign nest_depth    = out_res.depth;
  assign status        = out_res.status;
  assign last_result   = out_res.last;

endmodule

>>> sv/btok_checker.sv
`include "assert_macros.svh"

module btok_checker import btok_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         token_kind,
  input logic signed [63:0] int_value,
  input logic [30:0]        string_length,
  input logic [7:0]         out_byte,
  input logic [5:0]         nest_depth,
  input logic [2:0]         status,
  input logic               last_result
);

  logic [115:0] out_word;

  assign out_word = {token_kind, int_value, string_length, out_byte, nest_depth, status,
                     last_result};

  `CHK_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `CHK_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_word), "stalled result changed")
  `CHK_ASSERT(a_status_finish, out_valid && token_kind != TK_FINISH |-> status == ST_OK, "bad status")
  `CHK_ASSERT(a_finish_last, out_valid && token_kind == TK_FINISH |-> last_result, "finish not last")
  `CHK_ASSERT_RST(a_reset_empty, rst |=> !out_valid && in_ready, "not empty after reset")

endmodule

bind bencode_stream_tokenizer_core btok_checker u_btok_checker (.*);

>>> test/bencode_stream_tokenizer_core_tb.sv
`timescale 1ns / 1ps

module bencode_stream_tokenizer_core_tb;
  import btok_pkg::*;

  localparam int DEPTH       = MAX_DEPTH_DEF;
  localparam int PHASE_ITEMS = 510;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT       = 400000;

  typedef enum logic [2:0] {MD_IDLE, MD_INT, MD_LEN, MD_STR, MD_DONE} mode_e;
  typedef enum logic [1:0] {IP_PRE, IP_RUN, IP_STOP} int_phase_e;

  typedef struct {
    logic [7:0] b;
    logic       fin;
    logic       typed;
    res_t       tok;
  } req_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        fin;
    logic        typed;
    kind_t       kind;
    logic [5:0]  depth;
    status_t     st;
    logic [30:0] slen;
  } drow_t;

  localparam int NDIR = 29;
  localparam drow_t DIR_TAB [NDIR] = '{
    '{CH_E,     1'b0, 1'b1, TK_FINISH, 6'd0, ST_UNMATCHED, 31'd0},
    '{8'h78,    1'b1, 1'b0, TK_ODICT,  6'd0, ST_OK,        31'd0},
    '{CH_L,     1'b0, 1'b1, TK_OLIST,  6'd1, ST_OK,        31'd0},
    '{CH_I,     1'b0, 1'b0, TK_ODICT,  6'd0, ST_OK,        31'd0},
    '{CH_SPACE, 1'b0, 1'b0, TK_ODICT,  6'd0, ST_OK,        31'd0},
    '{CH_MINUS, 1'b0, 1'b0, TK_ODICT,  6'd0, ST_OK,        31'd0},
    '{8'h31,    1'b0, 1'b0, TK_ODICT,  6'd0, ST_OK,        31'd0},
    '{8'h32,    1'b0, 1'b0, TK_ODICT,  6'd0, ST_OK,        31'd0},
    '{8'h78,    1'b0, 1'b0, TK_ODICT,  6'd0, ST_OK,        31'd0},
    '{8'h33,    1'b0, 1'b0, TK_ODICT,  6'd0, ST_OK,        31'd0},
    '{CH_E,     1'b0, 1'b0, TK_ODICT,  6'd0, ST_OK,        31'd0},
    '{CH_ZERO,  1'b0, 1'b0, TK_ODICT,  6'd0, ST_OK,        31'd0},
    '{CH_COLON, 1'b0, 1'b1, TK_SHDR,   6'd1, ST_OK,        31'd0},
    '{8'h32,    1'b0, 1'b0, TK_ODICT,  6'd0, ST_OK,        31'd0},
    '{CH_COLON, 1'b0, 1'b0, TK_ODICT,  6'd0, ST_OK,        31'd0},
    '{8'h00,    1'b0, 1'b0, TK_ODICT,  6'd0, ST_OK,        31'd0},
    '{8'hFF,    1'b0, 1'b0, TK_ODICT,  6'd0, ST_OK,        31'd0},
    '{CH_D,     1'b0, 1'b1, TK_ODICT,  6'd2, ST_OK,        31'd0},
    '{8'h35,    1'b0, 1'b0, TK_ODICT,  6'd0, ST_OK,        31'd0},
    '{8'h71,    1'b0, 1'b1, TK_FINISH, 6'd2, ST_BAD,       31'd0},
    '{CH_E,     1'b1, 1'b0, TK_ODICT,  6'd0, ST_OK,        31'd0},
    '{CH_D,     1'b0, 1'b1, TK_ODICT,  6'd1, ST_OK,        31'd0},
    '{CH_E,     1'b0, 1'b0, TK_ODICT,  6'd0, ST_OK,        31'd0},
    '{CH_E,     1'b1, 1'b0, TK_ODICT,  6'd0, ST_OK,        31'd0},
    '{CH_I,     1'b0, 1'b0, TK_ODICT,  6'd0, ST_OK,        31'd0},
    '{8'h37,    1'b1, 1'b1, TK_FINISH, 6'd0, ST_INT_OPEN,  31'd0},
    '{CH_L,     1'b0, 1'b1, TK_OLIST,  6'd1, ST_OK,        31'd0},
    '{8'h7F,    1'b1, 1'b1, TK_FINISH, 6'd1, ST_BAD,       31'd0},
    '{8'h80,    1'b1, 1'b1, TK_FINISH, 6'd0, ST_OK,        31'd0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         data_byte = 8'd0;
  logic               stream_end = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         token_kind;
  logic signed [63:0] int_value;
  logic [30:0]        string_length;
  logic [7:0]         out_byte;
  logic [5:0]         nest_depth;
  logic [2:0]         status;
  logic               last_result;

  bencode_stream_tokenizer_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .stream_end    (stream_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .token_kind    (token_kind),
    .int_value     (int_value),
    .string_length (string_length),
    .out_byte      (out_byte),
    .nest_depth    (nest_depth),
    .status        (status),
    .last_result   (last_result)
  );

  always #4 clk = ~clk;

  // tokenizer shadow state
  mode_e       md;
  logic [63:0] iacc;
  int_phase_e  iph;
  logic        ineg;
  int unsigned lacc;
  int unsigned left;
  logic        stk [DEPTH];
  logic [5:0]  open_cnt;

  res_t  new_tokens [$];
  res_t  due_tokens [$];
  req_t  byte_q [$];
  req_t  offer;
  logic  [7:0] strm [$];

  int    errors = 0;
  int    gen_items;
  int    send_idle = 0;
  int    recv_idle = 0;
  int    hold_len = 0;
  int    hold_left = 0;
  logic  in_taken = 1'b0;

  task automatic clear_state();
    md       = MD_IDLE;
    iacc     = 64'd0;
    iph      = IP_PRE;
    ineg     = 1'b0;
    lacc     = 0;
    left     = 0;
    open_cnt = 6'd0;
  endtask

  task automatic emit(kind_t k, logic [63:0] iv, logic [30:0] sl, logic [7:0] ob, status_t st);
    new_tokens.insert(new_tokens.size(), '{kind: k, ival: iv, slen: sl, data: ob,
                                           depth: open_cnt, status: st, last: 1'b0});
  endtask

  task automatic finish_parse(status_t st);
    emit(TK_FINISH, 64'd0, 31'd0, 8'd0, st);
    md = MD_DONE;
  endtask

  task automatic open_box(logic is_list);
    if (open_cnt >= DEPTH) begin
      finish_parse(ST_OVERFLOW);
    end else begin
      stk[open_cnt] = is_list;
      open_cnt++;
      if (is_list) emit(TK_OLIST, 64'd0, 31'd0, 8'd0, ST_OK);
      else emit(TK_ODICT, 64'd0, 31'd0, 8'd0, ST_OK);
    end
  endtask

  // atoll-style conversion: skip leading white space, one sign, then digits
  task automatic int_step(logic [7:0] b);
    logic digit;
    digit = (b >= CH_ZERO && b <= CH_NINE);
    if (iph == IP_PRE) begin
      if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) return;
      if (b == CH_PLUS || b == CH_MINUS) begin
        ineg = (b == CH_MINUS);
        iph  = IP_RUN;
        return;
      end
      iph = digit ? IP_RUN : IP_STOP;
    end else if (iph == IP_RUN && !digit) begin
      iph = IP_STOP;
    end
    if (iph == IP_RUN && digit) iacc = iacc * 10 + 64'(b - CH_ZERO);
  endtask

  task automatic tokenize(logic [7:0] b, logic fin);
    int unsigned d;
    status_t     st;
    new_tokens.delete();
    case (md)
      MD_STR: begin
        emit(TK_SBYTE, 64'd0, 31'd0, b, ST_OK);
        left--;
        if (left == 0) md = MD_IDLE;
      end
      MD_LEN: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          d = b - CH_ZERO;
          // saturate instead of wrapping
          if (lacc > (LEN_MAX - d) / 10) lacc = LEN_MAX;
          else lacc = lacc * 10 + d;
        end else if (b == CH_COLON) begin
          emit(TK_SHDR, 64'd0, lacc[30:0], 8'd0, ST_OK);
          left = lacc;
          lacc = 0;
          md   = (left == 0) ? MD_IDLE : MD_STR;
        end else begin
          finish_parse(ST_BAD);
        end
      end
      MD_INT: begin
        if (b == CH_E) begin
          emit(TK_INT, ineg ? 64'd0 - iacc : iacc, 31'd0, 8'd0, ST_OK);
          iacc = 64'd0;
          iph  = IP_PRE;
          ineg = 1'b0;
          md   = MD_IDLE;
        end else begin
          int_step(b);
        end
      end
      MD_IDLE: begin
        if (b == CH_D) begin
          open_box(1'b0);
        end else if (b == CH_L) begin
          open_box(1'b1);
        end else if (b == CH_I) begin
          iacc = 64'd0;
          iph  = IP_PRE;
          ineg = 1'b0;
          md   = MD_INT;
        end else if (b == CH_E) begin
          if (open_cnt == 0) begin
            finish_parse(ST_UNMATCHED);
          end else begin
            open_cnt--;
            if (stk[open_cnt]) begin
              emit(TK_CLIST, 64'd0, 31'd0, 8'd0, ST_OK);
            end else begin
              emit(TK_CDICT, 64'd0, 31'd0, 8'd0, ST_OK);
              // closing the outermost dict ends the parse
              if (open_cnt == 0) finish_parse(ST_OK);
            end
          end
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
          lacc = b - CH_ZERO;
          md   = MD_LEN;
        end else begin
          if (open_cnt == 0) finish_parse(ST_OK);
          else finish_parse(ST_BAD);
        end
      end
      default: ;
    endcase
    if (fin) begin
      if (md != MD_DONE) begin
        if (md == MD_INT) st = ST_INT_OPEN;
        else if (md == MD_LEN || md == MD_STR) st = ST_BAD;
        else if (open_cnt == 0) st = ST_OK;
        else st = ST_BAD;
        finish_parse(st);
      end
      clear_state();
    end
    if (new_tokens.size() > 0) new_tokens[new_tokens.size() - 1].last = 1'b1;
  endtask

  // ---------------- stream builders ----------------

  function automatic logic [7:0] pick_tokenish();
    case ($urandom_range(0, 7))
      0: return CH_D;
      1: return CH_L;
      2: return CH_I;
      3: return CH_E;
      4: return CH_COLON;
      5: return 8'(CH_ZERO + $urandom_range(0, 9));
      6: return ($urandom_range(0, 1) != 0) ? CH_MINUS : CH_SPACE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_byte(logic [7:0] v);
    strm.insert(strm.size(), v);
  endtask

  task automatic push_text(string s);
    for (int k = 0; k < s.len(); k++) add_byte(s[k]);
  endtask

  task automatic put_int();
    int         n;
    logic [7:0] g;
    add_byte(CH_I);
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: push_text("9223372036854775807");
        1: push_text("-9223372036854775808");
        2: push_text("18446744073709551615");
        default: push_text("-0");
      endcase
    end else begin
      if ($urandom_range(0, 3) == 0)
        add_byte(($urandom_range(0, 1) != 0) ? CH_SPACE : 8'($urandom_range(9, 13)));
      case ($urandom_range(0, 2))
        1: add_byte(CH_PLUS);
        2: add_byte(CH_MINUS);
        default: ;
      endcase
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 5);
      for (int k = 0; k < n; k++) add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
      if ($urandom_range(0, 5) == 0) begin
        g = 8'($urandom_range(0, 255));
        if (g == CH_E) g = CH_PLUS;
        add_byte(g);
        if ($urandom_range(0, 1) != 0) add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
      end
    end
    add_byte(CH_E);
  endtask

  task automatic put_str();
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
    if ($urandom_range(0, 9) == 0) add_byte(CH_ZERO);
    push_text($sformatf("%0d", n));
    add_byte(CH_COLON);
    for (int k = 0; k < n; k++) add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic put_value(int lvl);
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      put_int();
    end else if (r < 55 || lvl >= 4) begin
      put_str();
    end else if (r < 75) begin
      add_byte(CH_L);
      n = $urandom_range(0, 3);
      for (int k = 0; k < n; k++) put_value(lvl + 1);
      add_byte(CH_E);
    end else begin
      put_dict(lvl + 1);
    end
  endtask

  task automatic put_dict(int lvl);
    int n;
    add_byte(CH_D);
    n = $urandom_range(0, 3);
    for (int k = 0; k < n; k++) begin
      put_str();
      put_value(lvl + 1);
    end
    add_byte(CH_E);
  endtask

  task automatic make_stream(int sel);
    int kind_sel;
    int n;
    int idx;
    strm.delete();
    kind_sel = (sel >= 0) ? sel : $urandom_range(0, 99);
    if (kind_sel < 35) begin
      put_dict(0);
      n = $urandom_range(0, 2);
      for (int k = 0; k < n; k++) add_byte(pick_tokenish());
    end else if (kind_sel < 50) begin
      // cut a well-formed stream short
      put_dict(0);
      idx = $urandom_range(1, strm.size());
      while (strm.size() > idx) strm.delete(strm.size() - 1);
    end else if (kind_sel < 60) begin
      put_dict(0);
      idx = $urandom_range(0, strm.size() - 1);
      strm[idx] = pick_tokenish();
    end else if (kind_sel < 70) begin
      n = $urandom_range(1, 3);
      for (int k = 0; k < n; k++) put_value(1);
    end else if (kind_sel < 78) begin
      // nest up to and past the stack limit
      n = $urandom_range(30, 36);
      for (int k = 0; k < n; k++) add_byte(($urandom_range(0, 1) != 0) ? CH_L : CH_D);
      if ($urandom_range(0, 1) != 0) put_int();
      n = $urandom_range(0, n);
      for (int k = 0; k < n; k++) add_byte(CH_E);
    end else if (kind_sel < 85) begin
      if ($urandom_range(0, 1) != 0) add_byte(CH_L);
      case ($urandom_range(0, 2))
        0: push_text("2147483647");
        1: push_text("2147483648");
        default: push_text("99999999999");
      endcase
      if ($urandom_range(0, 3) != 0) add_byte(CH_COLON);
      n = $urandom_range(0, 3);
      for (int k = 0; k < n; k++) add_byte(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 8);
      for (int k = 0; k < n; k++) add_byte(pick_tokenish());
    end
    foreach (strm[k])
      byte_q.insert(byte_q.size(),
                    '{b: strm[k], fin: (k == strm.size() - 1), typed: 1'b0, tok: '0});
    gen_items += strm.size();
  endtask

  task automatic check_field(string nm, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, nm, want, got);
      errors++;
    end
  endtask

  // ---------------- sender / receiver ----------------

  always @(negedge clk) begin
    if (!rst && !(in_valid && !in_taken)) begin
      in_taken = 1'b0;
      if (byte_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        offer = byte_q.pop_front();
        in_valid   <= 1'b1;
        data_byte  <= offer.b;
        stream_end <= offer.fin;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len  = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin : mon
    res_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        tokenize(offer.b, offer.fin);
        if (offer.typed) begin
          new_tokens.delete();
          new_tokens.insert(0, offer.tok);
        end
        foreach (new_tokens[k]) due_tokens.insert(due_tokens.size(), new_tokens[k]);
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (due_tokens.size() == 0) begin
          $display("%0t: unexpected token, expected none, got kind %0d", $time, token_kind);
          errors++;
        end else begin
          want = due_tokens.pop_front();
          check_field("token_kind", 64'(token_kind), 64'(want.kind));
          check_field("int_value", int_value, want.ival);
          check_field("string_length", 64'(string_length), 64'(want.slen));
          check_field("out_byte", 64'(out_byte), 64'(want.data));
          check_field("nest_depth", 64'(nest_depth), 64'(want.depth));
          check_field("status", 64'(status), 64'(want.status));
          check_field("last_result", 64'(last_result), 64'(want.last));
        end
      end
    end
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    drow_t row;
    clear_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 13 : (ph == 1) ? 54 : 0;
      recv_idle = (ph == 0) ? 54 : (ph == 1) ? 13 : 0;
      gen_items = 0;
      if (ph == 0) begin
        for (int k = 0; k < NDIR; k++) begin
          row = DIR_TAB[k];
          byte_q.insert(byte_q.size(),
                        '{b: row.b, fin: row.fin, typed: row.typed,
                          tok: '{kind: row.kind, ival: 64'd0, slen: row.slen, data: 8'd0,
                                 depth: row.depth, status: row.st, last: 1'b1}});
        end
        make_stream(70);
      end
      while (gen_items < PHASE_ITEMS) make_stream(-1);
      // starve the output while input keeps coming
      if (ph == 2) hold_len = HOLD_CYCLES;
      while (byte_q.size() != 0 || in_valid) @(posedge clk);
      while (due_tokens.size() != 0) @(posedge clk);
      repeat (12) @(posedge clk);
    end
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
